/* rtl/ppa_pkg.sv */
// Package for the per-processor page allocator.
// Holds field widths, parameter defaults, operation and status codes, and the sequencer states.
`default_nettype none
package ppa_pkg;

    localparam int CPUS_DEF  = 8;
    localparam int PAGES_DEF = 32768;

    localparam int PAGE_W   = 15;
    localparam int CPU_W    = 3;
    localparam int STATUS_W = 2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFREE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HEAD_D,
        S_POP,
        S_SCAN,
        S_VHEAD,
        S_CNT,
        S_TAKE,
        S_WALK,
        S_FIX,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

/* rtl/ppa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ppa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* rtl/ppa_alu.sv */
// Shared increment-and-compare unit of the allocator sequencer.
// Gives a+1 and whether a+1 is below a limit; no dependencies.
`default_nettype none
module ppa_alu #(
    parameter int W = 8
) (
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    output logic      [W-1:0] o_sum,
    output logic              o_lt
);

    assign o_sum = i_a + W'(1);
    assign o_lt  = (o_sum < i_b);

endmodule
`default_nettype wire

/* rtl/per_cpu_page_allocator_with_steal.sv */
// Per-processor LIFO page allocator with stealing: top level and sequencer.
// Free passes S_HEAD_D to S_DONE; a refused free goes straight to S_DONE; own-list allocate adds S_POP.
// Steal scans the other lists in S_SCAN, counts the n pages of the victim list in S_CNT, walks t = ceil(n/2) in S_WALK;
// the link-table read port sets the walk rate at one page per cycle.
// One item at a time. Reset empties all lists at once; no clearing pass.
// Uses ppa_pkg, ppa_ram and ppa_alu.
`default_nettype none
module per_cpu_page_allocator_with_steal #(
    parameter int NUM_CPUS  = ppa_pkg::CPUS_DEF,
    parameter int NUM_PAGES = ppa_pkg::PAGES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [ppa_pkg::PAGE_W-1:0]    i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_operation,
    input  wire logic [ppa_pkg::CPU_W-1:0]     i_cpu,
    input  wire logic [ppa_pkg::PAGE_W-1:0]    i_page_number,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [ppa_pkg::PAGE_W-1:0]    o_granted_page,
    output logic      [ppa_pkg::STATUS_W-1:0]  o_status,
    output logic                               o_stolen
);

    import ppa_pkg::*;

    localparam int CW = $clog2(NUM_CPUS);
    localparam int AW = $clog2(NUM_PAGES);
    localparam int LW = $clog2(NUM_PAGES + 1);
    localparam int UW = ((LW > CW) ? LW : CW) + 1;
    localparam int WW = (LW > PAGE_W) ? LW : PAGE_W;
    localparam int MOD_STEPS = (2 ** CPU_W) / 2;
    localparam logic [LW-1:0] EMPTY = LW'(NUM_PAGES);

    t_state                r_state, n_state;
    logic                  r_op, n_op;
    logic [CW-1:0]         r_me, n_me;
    logic [AW-1:0]         r_page, n_page;
    logic [CW-1:0]         r_victim, n_victim;
    logic [AW-1:0]         r_vhead, n_vhead;
    logic [LW-1:0]         r_second, n_second;
    logic [LW-1:0]         r_n, n_n;
    logic [LW-1:0]         r_k, n_k;
    logic [LW-1:0]         r_take, n_take;
    logic [AW-1:0]         r_last, n_last;
    logic [AW-1:0]         r_granted, n_granted;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic                  r_stolen, n_stolen;
    logic [NUM_CPUS-1:0]   r_nonempty, n_nonempty;
    logic [PAGE_W-1:0]     r_lowest;
    logic                  r_o_valid, n_o_valid;
    logic [PAGE_W-1:0]     r_o_granted, n_o_granted;
    logic [STATUS_W-1:0]   r_o_status, n_o_status;
    logic                  r_o_stolen, n_o_stolen;

    logic                  head_we;
    logic [CW-1:0]         head_waddr;
    logic [AW-1:0]         head_wdata;
    logic [CW-1:0]         head_raddr;
    logic [AW-1:0]         head_rd;
    logic                  link_we;
    logic [AW-1:0]         link_waddr;
    logic [LW-1:0]         link_wdata;
    logic [AW-1:0]         link_raddr;
    logic [LW-1:0]         link_rd;

    logic [UW-1:0]         alu_a, alu_b, alu_sum;
    logic                  alu_lt;

    logic [CW-1:0]         me_mod;
    logic [6:0]            cpu_work;
    logic                  refuse;
    logic [WW-1:0]         page_ext;
    logic                  link_ok;
    logic [CW-1:0]         v_next;
    logic                  keep;

    ppa_ram #(.WIDTH(AW), .DEPTH(NUM_CPUS)) u_head (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (head_waddr),
        .i_wdata (head_wdata),
        .i_raddr (head_raddr),
        .o_rdata (head_rd)
    );

    ppa_ram #(.WIDTH(LW), .DEPTH(NUM_PAGES)) u_link (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rd)
    );

    ppa_alu #(.W(UW)) u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_sum (alu_sum),
        .o_lt  (alu_lt)
    );

    always_comb begin
        cpu_work = 7'(i_cpu);
        for (int i = 0; i < MOD_STEPS; i++) begin
            if (cpu_work >= 7'(NUM_CPUS)) begin
                cpu_work = cpu_work - 7'(NUM_CPUS);
            end
        end
        me_mod = CW'(cpu_work);
    end

    assign page_ext = WW'(i_page_number);
    assign refuse   = (i_operation == OP_FREE) &&
                      ((i_page_number < r_lowest) || (page_ext >= WW'(NUM_PAGES)));
    assign link_ok  = (link_rd < EMPTY);

    assign o_cfg_ready    = 1'b1;
    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_o_valid;
    assign o_granted_page = r_o_granted;
    assign o_status       = r_o_status;
    assign o_stolen       = r_o_stolen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_nonempty <= '0;
            r_lowest   <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_nonempty <= n_nonempty;
            r_o_valid  <= n_o_valid;
            if (i_cfg_valid) begin
                r_lowest <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_me        <= n_me;
        r_page      <= n_page;
        r_victim    <= n_victim;
        r_vhead     <= n_vhead;
        r_second    <= n_second;
        r_n         <= n_n;
        r_k         <= n_k;
        r_take      <= n_take;
        r_last      <= n_last;
        r_granted   <= n_granted;
        r_status    <= n_status;
        r_stolen    <= n_stolen;
        r_o_granted <= n_o_granted;
        r_o_status  <= n_o_status;
        r_o_stolen  <= n_o_stolen;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_me        = r_me;
        n_page      = r_page;
        n_victim    = r_victim;
        n_vhead     = r_vhead;
        n_second    = r_second;
        n_n         = r_n;
        n_k         = r_k;
        n_take      = r_take;
        n_last      = r_last;
        n_granted   = r_granted;
        n_status    = r_status;
        n_stolen    = r_stolen;
        n_nonempty  = r_nonempty;
        n_o_valid   = r_o_valid;
        n_o_granted = r_o_granted;
        n_o_status  = r_o_status;
        n_o_stolen  = r_o_stolen;

        head_we    = 1'b0;
        head_waddr = r_me;
        head_wdata = r_page;
        head_raddr = r_me;
        link_we    = 1'b0;
        link_waddr = r_page;
        link_wdata = EMPTY;
        link_raddr = r_last;
        alu_a      = '0;
        alu_b      = '0;
        v_next     = '0;
        keep       = 1'b0;

        if (r_o_valid && i_out_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                head_raddr = me_mod;
                if (i_in_valid) begin
                    n_op      = i_operation;
                    n_me      = me_mod;
                    n_page    = AW'(i_page_number);
                    n_victim  = me_mod;
                    n_granted = '0;
                    n_status  = ST_DONE;
                    n_stolen  = 1'b0;
                    if (refuse) begin
                        n_status = ST_REFUSED;
                        n_state  = S_DONE;
                    end else if (i_operation == OP_FREE || r_nonempty[me_mod]) begin
                        n_state = S_HEAD_D;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_HEAD_D: begin
                if (r_op == OP_FREE) begin
                    link_we    = 1'b1;
                    link_waddr = r_page;
                    link_wdata = r_nonempty[r_me] ? LW'(head_rd) : EMPTY;
                    head_we    = 1'b1;
                    head_waddr = r_me;
                    head_wdata = r_page;
                    n_nonempty[r_me] = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    n_granted  = head_rd;
                    link_raddr = head_rd;
                    n_state    = S_POP;
                end
            end
            S_POP: begin
                head_we    = link_ok;
                head_waddr = r_me;
                head_wdata = AW'(link_rd);
                n_nonempty[r_me] = link_ok;
                n_state    = S_DONE;
            end
            S_SCAN: begin
                alu_a  = UW'(r_victim);
                alu_b  = UW'(NUM_CPUS);
                v_next = alu_lt ? CW'(alu_sum) : '0;
                n_victim   = v_next;
                head_raddr = v_next;
                if (v_next == r_me) begin
                    n_status = ST_NOFREE;
                    n_state  = S_DONE;
                end else if (r_nonempty[v_next]) begin
                    n_state = S_VHEAD;
                end
            end
            S_VHEAD: begin
                n_vhead    = head_rd;
                link_raddr = head_rd;
                n_n        = '0;
                n_state    = S_CNT;
            end
            S_CNT: begin
                alu_a = UW'(r_n);
                alu_b = UW'(NUM_PAGES);
                n_n   = LW'(alu_sum);
                if (r_n == '0) begin
                    n_second = link_rd;
                end
                link_raddr = AW'(link_rd);
                if (!(link_ok && alu_lt)) begin
                    n_state = S_TAKE;
                end
            end
            S_TAKE: begin
                alu_a      = UW'(r_n);
                n_take     = LW'(alu_sum >> 1);
                link_raddr = r_vhead;
                n_last     = r_vhead;
                n_k        = '0;
                n_state    = S_WALK;
            end
            S_WALK: begin
                alu_a = UW'(r_k);
                alu_b = UW'(r_take);
                if (alu_lt) begin
                    n_last     = AW'(link_rd);
                    n_k        = LW'(alu_sum);
                    link_raddr = AW'(link_rd);
                end else begin
                    head_we    = link_ok;
                    head_waddr = r_victim;
                    head_wdata = AW'(link_rd);
                    n_nonempty[r_victim] = link_ok;
                    link_we    = 1'b1;
                    link_waddr = r_last;
                    link_wdata = EMPTY;
                    n_state    = S_FIX;
                end
            end
            S_FIX: begin
                keep       = (r_last != r_vhead) && (r_second < EMPTY);
                head_we    = keep;
                head_waddr = r_me;
                head_wdata = AW'(r_second);
                n_nonempty[r_me] = keep;
                n_granted  = r_vhead;
                n_stolen   = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_o_valid || i_out_ready) begin
                    n_o_valid   = 1'b1;
                    n_o_granted = PAGE_W'(r_granted);
                    n_o_status  = r_status;
                    n_o_stolen  = r_stolen;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* dv/page_alloc_checker.sv */
// Checker for the per-processor page allocator: watches the config, request and result channels.
// Keeps its own copy of the free lists and link table, predicts each result, compares in order.
// Depends on ppa_pkg for widths and codes.
module page_alloc_checker #(
    parameter int NUM_CPUS  = ppa_pkg::CPUS_DEF,
    parameter int NUM_PAGES = ppa_pkg::PAGES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [ppa_pkg::PAGE_W-1:0]   i_cfg_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic                         i_operation,
    input  logic [ppa_pkg::CPU_W-1:0]    i_cpu,
    input  logic [ppa_pkg::PAGE_W-1:0]   i_page_number,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [ppa_pkg::PAGE_W-1:0]   i_granted_page,
    input  logic [ppa_pkg::STATUS_W-1:0] i_status,
    input  logic                         i_stolen,
    output int                           o_fail_count,
    output int                           o_pending
);

    import ppa_pkg::*;

    typedef struct packed {
        logic [PAGE_W-1:0]   granted;
        logic [STATUS_W-1:0] status;
        logic                stolen;
    } t_alloc_result;

    localparam logic [15:0] NO_PAGE = 16'(NUM_PAGES);

    logic [15:0]       head_of [NUM_CPUS];
    logic [15:0]       link_tab [NUM_PAGES];
    logic [PAGE_W-1:0] floor_page;
    t_alloc_result     grant_q [$];

    function automatic logic [15:0] next_of(input logic [15:0] pg);
        if (pg >= NUM_PAGES) return NO_PAGE;
        return (link_tab[pg] < NUM_PAGES) ? link_tab[pg] : NO_PAGE;
    endfunction

    task automatic predict_alloc(input logic op, input logic [CPU_W-1:0] cpu,
                                 input logic [PAGE_W-1:0] page, output t_alloc_result r);
        int          me;
        int          victim;
        int          n;
        int          take;
        bit          found;
        logic [15:0] pg;
        logic [15:0] first;
        logic [15:0] last;
        me = int'(cpu) % NUM_CPUS;
        r = '0;
        r.status = ST_DONE;
        if (op == OP_FREE) begin
            if (page < floor_page || int'(page) >= NUM_PAGES) begin
                r.status = ST_REFUSED;
            end else begin
                link_tab[page] = head_of[me];
                head_of[me] = 16'(page);
            end
        end else if (head_of[me] < NUM_PAGES) begin
            r.granted = head_of[me][PAGE_W-1:0];
            head_of[me] = next_of(head_of[me]);
        end else begin
            found = 0;
            victim = me;
            for (int i = 1; i < NUM_CPUS && !found; i++) begin
                victim = (victim + 1) % NUM_CPUS;
                if (head_of[victim] < NUM_PAGES) found = 1;
            end
            if (!found) begin
                r.status = ST_NOFREE;
            end else begin
                // count the victim list, capped for looped lists
                first = head_of[victim];
                n = 0;
                pg = first;
                while (pg < NUM_PAGES && n < NUM_PAGES) begin
                    n++;
                    pg = next_of(pg);
                end
                take = (n + 1) / 2;
                last = first;
                for (int k = 1; k < take; k++) last = next_of(last);
                head_of[victim] = next_of(last);
                link_tab[last] = NO_PAGE;
                head_of[me] = next_of(first);
                r.granted = first[PAGE_W-1:0];
                r.stolen = 1'b1;
            end
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_alloc_result want;
        t_alloc_result got;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CPUS; i++) head_of[i] = NO_PAGE;
            floor_page = '0;
            grant_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) floor_page = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                got.granted = i_granted_page;
                got.status  = i_status;
                got.stolen  = i_stolen;
                if (grant_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, %s %0d %s %0d %s %0d",
                             $time, "got page", got.granted, "status", got.status,
                             "stolen", got.stolen);
                    o_fail_count++;
                end else begin
                    want = grant_q.pop_front();
                    if (got.granted !== want.granted) begin
                        $display("%0t: granted_page mismatch: expected %0d, got %0d",
                                 $time, want.granted, got.granted);
                        o_fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, got.status);
                        o_fail_count++;
                    end
                    if (got.stolen !== want.stolen) begin
                        $display("%0t: stolen mismatch: expected %0d, got %0d",
                                 $time, want.stolen, got.stolen);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_alloc(i_operation, i_cpu, i_page_number, want);
                grant_q.push_back(want);
            end
        end
        o_pending = grant_q.size();
    end

endmodule

/* dv/tb.sv */
// Testbench top for the per-processor page allocator: clock, reset, stimulus and verdict.
// Drives directed and random requests with random idling; checking lives in page_alloc_checker.
// Depends on ppa_pkg, page_alloc_checker and the allocator RTL.
module tb;
    import ppa_pkg::*;

    localparam int WATCH_LIMIT = 250000;
    localparam int HOLD_CYCLES = 400;
    localparam int PAGE_MAX    = (1 << PAGE_W) - 1;
    localparam int PHASE_ITEMS = 570;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [PAGE_W-1:0]   cfg_data  = '0;
    logic                in_valid  = 1'b0;
    logic                operation = OP_ALLOC;
    logic [CPU_W-1:0]    cpu       = '0;
    logic [PAGE_W-1:0]   page      = '0;
    logic                out_ready = 1'b0;
    logic                cfg_ready;
    logic                in_ready;
    logic                out_valid;
    logic [PAGE_W-1:0]   granted;
    logic [STATUS_W-1:0] status;
    logic                stolen;

    int fails;
    int pending;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_token  = 0;
    bit page_used [PAGE_MAX+1];

    per_cpu_page_allocator_with_steal dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_operation    (operation),
        .i_cpu          (cpu),
        .i_page_number  (page),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_granted_page (granted),
        .o_status       (status),
        .o_stolen       (stolen)
    );

    page_alloc_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_operation    (operation),
        .i_cpu          (cpu),
        .i_page_number  (page),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_granted_page (granted),
        .i_status       (status),
        .i_stolen       (stolen),
        .o_fail_count   (fails),
        .o_pending      (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin : result_sink
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(negedge clk);
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCH_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_request(input logic op, input logic [CPU_W-1:0] c,
                                input logic [PAGE_W-1:0] pg);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        cpu       <= c;
        page      <= pg;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_floor(input logic [PAGE_W-1:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_request(input int alloc_pct, input logic [PAGE_W-1:0] floor);
        logic [CPU_W-1:0]  c;
        logic [PAGE_W-1:0] pg;
        int                tries;
        c = CPU_W'($urandom);
        if ($urandom_range(99) < alloc_pct) begin
            send_request(OP_ALLOC, c, PAGE_W'($urandom));
        end else if (floor > 0 && $urandom_range(9) == 0) begin
            send_request(OP_FREE, c, PAGE_W'($urandom_range(floor - 1)));
        end else begin
            // keep freed pages unique so no list loops back on itself
            tries = 0;
            pg = PAGE_W'($urandom_range(PAGE_MAX, floor));
            while (page_used[pg] && tries < 32) begin
                pg = PAGE_W'($urandom_range(PAGE_MAX, floor));
                tries++;
            end
            if (page_used[pg]) begin
                send_request(OP_ALLOC, c, pg);
            end else begin
                page_used[pg] = 1'b1;
                send_request(OP_FREE, c, pg);
            end
        end
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input logic [PAGE_W-1:0] floor);
        int mix;
        write_floor(floor);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        mix = 50;
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 40 == 0) mix = $urandom_range(80, 20);
            if (i == 150) hold_token++;
            if (i == 300) drain_results();
            random_request(mix, floor);
        end
    endtask

    initial begin : stimulus
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        tx_idle_pct = 0;
        rx_idle_pct = 30;

        send_request(OP_ALLOC, 3'd0, '0);
        send_request(OP_FREE,  3'd0, '0);
        send_request(OP_FREE,  3'd7, PAGE_W'(PAGE_MAX));
        send_request(OP_FREE,  3'd7, 15'd100);
        send_request(OP_FREE,  3'd7, 15'd101);
        send_request(OP_ALLOC, 3'd0, PAGE_W'(PAGE_MAX));
        send_request(OP_ALLOC, 3'd0, '0);
        send_request(OP_ALLOC, 3'd6, '0);
        send_request(OP_ALLOC, 3'd7, '0);
        // repeated free of one page makes a looped list
        send_request(OP_FREE,  3'd3, 15'd200);
        send_request(OP_FREE,  3'd3, 15'd200);
        send_request(OP_ALLOC, 3'd3, '0);
        send_request(OP_ALLOC, 3'd4, '0);
        send_request(OP_ALLOC, 3'd3, '0);
        // one page shared by two lists
        send_request(OP_FREE,  3'd1, 15'd300);
        send_request(OP_FREE,  3'd2, 15'd300);
        send_request(OP_FREE,  3'd1, 15'd301);
        send_request(OP_ALLOC, 3'd2, '0);
        send_request(OP_ALLOC, 3'd1, '0);

        write_floor(PAGE_W'(PAGE_MAX));
        send_request(OP_FREE,  3'd5, PAGE_W'(PAGE_MAX - 1));
        send_request(OP_FREE,  3'd5, PAGE_W'(PAGE_MAX));
        send_request(OP_ALLOC, 3'd5, '0);
        send_request(OP_FREE,  3'd5, '0);

        page_used[0]        = 1'b1;
        page_used[100]      = 1'b1;
        page_used[101]      = 1'b1;
        page_used[200]      = 1'b1;
        page_used[300]      = 1'b1;
        page_used[301]      = 1'b1;
        page_used[PAGE_MAX] = 1'b1;

        run_phase(19, 65, PAGE_W'($urandom_range(4000, 1)));
        run_phase(65, 19, '0);
        run_phase(0, 0, PAGE_W'($urandom_range(32000, 16384)));

        drain_results();
        repeat (20) @(negedge clk);
        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/ppa_pkg.sv
rtl/ppa_ram.sv
rtl/ppa_alu.sv
rtl/per_cpu_page_allocator_with_steal.sv
dv/page_alloc_checker.sv
dv/tb.sv
